@@ rtl/core/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types, sizes and helpers for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

   // Table geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = IDX_W + 1;               // scan counter, holds ENTRIES
   localparam int OCC_W   = $clog2(ENTRIES + 1);     // occupancy, 0..ENTRIES
   localparam int CAP_W   = 5;                       // capacity register
   localparam int WORD_W  = 32;                      // key, value, count, stamp

   // Operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_OUT
   } state_type;

   // One stored entry
   typedef struct packed {
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] count;
      logic [WORD_W-1:0] stamp;
   } entry_type;

   // Result of one scan pass
   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [WORD_W-1:0] hit_value;
      logic [WORD_W-1:0] hit_count;
      logic              vic_found;
      logic [IDX_W-1:0]  vic_idx;
      logic [WORD_W-1:0] vic_key;
   } scan_result_type;

   // Response payload
   typedef struct packed {
      logic              hit;
      logic [WORD_W-1:0] read_value;
      logic              evicted;
      logic [WORD_W-1:0] evicted_key;
   } rsp_data_type;

   // Saturating increment
   function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] r;
      r = (v == '1) ? v : v + WORD_W'(1);
      return r;
   endfunction

endpackage

@@ rtl/core/lfu_if.sv @@
// ----------------------------------------------------------------------------
// lfu_if
// Valid/ready channels of the LFU cache table: request, response, config.
// ----------------------------------------------------------------------------

// Request channel
interface lfu_req_if;
   import lfu_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [WORD_W-1:0] lookup_key;
   logic [WORD_W-1:0] write_value;

   modport source (output valid, output op, output lookup_key, output write_value,
                   input ready);
   modport sink   (input valid, input op, input lookup_key, input write_value,
                   output ready);
endinterface

// Response channel
interface lfu_rsp_if;
   import lfu_pkg::*;
   logic              valid;
   logic              ready;
   logic              hit;
   logic [WORD_W-1:0] read_value;
   logic              evicted;
   logic [WORD_W-1:0] evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

// Capacity register write channel
interface lfu_csr_if;
   import lfu_pkg::*;
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/lfu_scan_unit.sv @@
// ----------------------------------------------------------------------------
// lfu_scan_unit
// Per-entry compare unit: looks for the key and tracks the eviction victim
// (lowest use count, then oldest stamp, then lowest index) one entry a cycle.
// ----------------------------------------------------------------------------
module lfu_scan_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     cmp_vld,
   input  logic [lfu_pkg::IDX_W-1:0]  cmp_idx,
   input  logic                     cmp_valid_bit,
   input  lfu_pkg::entry_type       cmp_entry,
   input  logic [lfu_pkg::WORD_W-1:0] key,
   output lfu_pkg::scan_result_type result
);
   import lfu_pkg::*;

   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [WORD_W-1:0] hit_value_ff, hit_value_in;
   logic [WORD_W-1:0] hit_count_ff, hit_count_in;
   logic              vic_ff, vic_in;
   logic [IDX_W-1:0]  vic_idx_ff, vic_idx_in;
   logic [WORD_W-1:0] vic_count_ff, vic_count_in;
   logic [WORD_W-1:0] vic_stamp_ff, vic_stamp_in;
   logic [WORD_W-1:0] vic_key_ff, vic_key_in;
   logic              better;

   // Victim order: strictly lower count, or equal count and older stamp
   always_comb begin
      better = !vic_ff ||
               (cmp_entry.count < vic_count_ff) ||
               ((cmp_entry.count == vic_count_ff) && (cmp_entry.stamp < vic_stamp_ff));
   end

   // Next state of the trackers
   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_value_in = hit_value_ff;
      hit_count_in = hit_count_ff;
      vic_in       = vic_ff;
      vic_idx_in   = vic_idx_ff;
      vic_count_in = vic_count_ff;
      vic_stamp_in = vic_stamp_ff;
      vic_key_in   = vic_key_ff;
      if (start) begin
         hit_in = 1'b0;
         vic_in = 1'b0;
      end else if (cmp_vld && cmp_valid_bit) begin
         // first matching entry wins
         if (!hit_ff && (cmp_entry.key == key)) begin
            hit_in       = 1'b1;
            hit_idx_in   = cmp_idx;
            hit_value_in = cmp_entry.value;
            hit_count_in = cmp_entry.count;
         end
         if (better) begin
            vic_in       = 1'b1;
            vic_idx_in   = cmp_idx;
            vic_count_in = cmp_entry.count;
            vic_stamp_in = cmp_entry.stamp;
            vic_key_in   = cmp_entry.key;
         end
      end
   end

   // Flags
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         vic_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         vic_ff <= vic_in;
      end
   end

   // Payload trackers
   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_value_ff <= hit_value_in;
      hit_count_ff <= hit_count_in;
      vic_idx_ff   <= vic_idx_in;
      vic_count_ff <= vic_count_in;
      vic_stamp_ff <= vic_stamp_in;
      vic_key_ff   <= vic_key_in;
   end

   always_comb begin
      result.hit       = hit_ff;
      result.hit_idx   = hit_idx_ff;
      result.hit_value = hit_value_ff;
      result.hit_count = hit_count_ff;
      result.vic_found = vic_ff;
      result.vic_idx   = vic_idx_ff;
      result.vic_key   = vic_key_ff;
   end

endmodule

@@ rtl/core/lfu_cache_table.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_table
// Fully associative key/value table with LFU replacement, LRU tie break.
// ----------------------------------------------------------------------------
// One request item is handled at a time. After the item is accepted the
// sequencer reads the 16-entry table one entry per cycle through the single
// read port of the entry memory, then writes back in the update state and
// loads the response register in the output state, which waits while that
// register is full and not taken. A new item is accepted only in idle. The
// response register lets a finished item wait while the next one is taken
// in. The capacity register may be written at any time the table is idle;
// a write is accepted every cycle. Reset empties the table at once through
// per-entry valid bits.
// ----------------------------------------------------------------------------
module lfu_cache_table (
   input  logic      clock,
   input  logic      reset,
   lfu_req_if.sink   req_ch,
   lfu_rsp_if.source rsp_ch,
   lfu_csr_if.sink   csr_ch
);
   import lfu_pkg::*;

   // Control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [WORD_W-1:0] touch_ff, touch_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Item payload and results
   logic              op_ff;
   logic [WORD_W-1:0] key_ff;
   logic [WORD_W-1:0] wval_ff;
   rsp_data_type      res_ff, res_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;

   // Entry memory
   entry_type         entry_mem [ENTRIES];
   entry_type         rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   entry_type         mem_wd;

   // Update decisions
   scan_result_type   scan;
   logic              accept;
   logic [OCC_W-1:0]  cap_eff;
   logic              evict;
   logic [ENTRIES-1:0] avail;
   logic              free_found;
   logic [IDX_W-1:0]  free_idx;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_W'(ENTRIES);
      end else if (csr_ch.valid) begin
         cap_ff <= csr_ch.data;
      end
   end

   // Item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_ch.op;
         key_ff  <= req_ch.lookup_key;
         wval_ff <= req_ch.write_value;
      end
   end

   // Entry memory: one read port for the scan, one write port for updates
   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem[scan_cnt_ff[IDX_W-1:0]];
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
   end

   // Compare index is registered from the read address, in step with the read data
   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_cnt_ff[IDX_W-1:0];
   end

   lfu_scan_unit u_scan (
      .clock         (clock),
      .reset         (reset),
      .start         (accept),
      .cmp_vld       (cmp_vld_ff),
      .cmp_idx       (cmp_idx_ff),
      .cmp_valid_bit (valid_ff[cmp_idx_ff]),
      .cmp_entry     (rd_data_ff),
      .key           (key_ff),
      .result        (scan)
   );

   // Effective capacity and eviction decision
   always_comb begin
      cap_eff = (cap_ff > CAP_W'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(cap_ff);
      evict   = (occ_ff >= cap_eff) && scan.vic_found;
      avail   = valid_ff;
      if (evict) begin
         avail[scan.vic_idx] = 1'b0;
      end
   end

   // Lowest free slot after eviction
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!avail[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Sequencer: next state and update
   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      cmp_vld_in   = 1'b0;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      touch_in     = touch_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;

      // response register drains independently
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            scan_cnt_in = '0;
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff < CNT_W'(ENTRIES)) begin
               cmp_vld_in  = 1'b1;
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            res_in = '0;
            if (scan.hit) begin
               res_in.hit        = 1'b1;
               res_in.read_value = (op_ff == OP_GET) ? scan.hit_value : '0;
               mem_we       = 1'b1;
               mem_wa       = scan.hit_idx;
               mem_wd.key   = key_ff;
               mem_wd.value = (op_ff == OP_PUT) ? wval_ff : scan.hit_value;
               mem_wd.count = sat_inc(scan.hit_count);
               mem_wd.stamp = touch_ff;
               touch_in     = sat_inc(touch_ff);
            end else if ((op_ff == OP_PUT) && (cap_eff != '0)) begin
               if (evict) begin
                  res_in.evicted     = 1'b1;
                  res_in.evicted_key = scan.vic_key;
               end
               valid_in = avail;
               if (free_found) begin
                  valid_in[free_idx] = 1'b1;
                  mem_we       = 1'b1;
                  mem_wa       = free_idx;
                  mem_wd.key   = key_ff;
                  mem_wd.value = wval_ff;
                  mem_wd.count = WORD_W'(1);
                  mem_wd.stamp = touch_ff;
                  touch_in     = sat_inc(touch_ff);
               end
               occ_in = occ_ff - OCC_W'(evict) + OCC_W'(free_found);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         touch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         touch_ff     <= touch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_data_ff.hit;
   assign rsp_ch.read_value  = rsp_data_ff.read_value;
   assign rsp_ch.evicted     = rsp_data_ff.evicted;
   assign rsp_ch.evicted_key = rsp_data_ff.evicted_key;

   // Occupancy always matches the number of valid entries
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(occ_ff))
      else $error("occupancy count out of step with valid bits");

   // A hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.hit && rsp_data_ff.evicted))
      else $error("response flags both hit and eviction");

   // An accepted item starts a scan from entry zero
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN) && (scan_cnt_ff == '0))
      else $error("accepted item did not start a scan");

   // The update state is always followed by the output state
   a_update_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (state_ff == ST_OUT))
      else $error("update state did not advance");

   // The table is only written during the update step
   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_UPDATE))
      else $error("entry memory written outside update");

endmodule

@@ tb/sv/lfu_cache_table_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_table_test
// Self-checking bench for the LFU cache table. A shadow copy of the table
// predicts hit, read value and eviction for every accepted request, and each
// response is checked against it in order. A short directed run covers
// overwrite, miss, count/age ties, capacity zero, capacity above the table
// size and capacity lowered below occupancy. Random phases at several
// capacities follow, with random idling on both channels and one long
// response stall that backs up the request channel.
// ----------------------------------------------------------------------------
module lfu_cache_table_test;
   import lfu_pkg::*;

   localparam logic [CAP_W-1:0] RESET_CAPACITY = 5'd16;
   localparam int POOL_MAX       = 32;
   localparam int ITEMS_PER_RUN  = 84;   // items per random phase, capacity above zero
   localparam int ITEMS_CAP_ZERO = 30;
   localparam int HOLD_AT        = 220;  // results before the long stall
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int TIMEOUT_NS     = 1000000;

   // -------------------------------------------------------------------------
   // Shadow table: predicts each response, holds the ones still owed
   // -------------------------------------------------------------------------
   class lfu_shadow_table;
      entry_type         slot [ENTRIES];
      bit                slot_live [ENTRIES];
      logic [WORD_W-1:0] stamp_now;
      int unsigned       occupancy;
      logic [CAP_W-1:0]  capacity;
      rsp_data_type      owed_rsp [$];
      int unsigned       failures;
      int unsigned       results_seen;

      function new();
         foreach (slot_live[i]) slot_live[i] = 1'b0;
         stamp_now    = '0;
         occupancy    = 0;
         capacity     = RESET_CAPACITY;
         failures     = 0;
         results_seen = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function void restamp(int i);
         slot[i].stamp = stamp_now;
         if (stamp_now != '1) stamp_now++;
      endfunction

      // Apply one accepted request and queue the response it owes
      function void take_request(logic op, logic [WORD_W-1:0] key,
                                 logic [WORD_W-1:0] val);
         rsp_data_type want;
         int           found;
         int           victim;
         int           limit;
         bit           placed;
         want   = '0;
         found  = -1;
         victim = -1;
         placed = 1'b0;
         limit  = (capacity > ENTRIES) ? ENTRIES : int'(capacity);

         for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && slot_live[i] && slot[i].key == key) found = i;

         if (found >= 0) begin
            want.hit = 1'b1;
            if (op == OP_GET) want.read_value = slot[found].value;
            else slot[found].value = val;
            if (slot[found].count != '1) slot[found].count++;
            restamp(found);
         end else if (op == OP_PUT && limit != 0) begin
            // full: drop lowest count, oldest stamp, lowest index
            if (occupancy >= limit) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_live[i] && (victim < 0 ||
                      slot[i].count < slot[victim].count ||
                      (slot[i].count == slot[victim].count &&
                       slot[i].stamp < slot[victim].stamp)))
                     victim = i;
               end
               if (victim >= 0) begin
                  want.evicted     = 1'b1;
                  want.evicted_key = slot[victim].key;
                  slot_live[victim] = 1'b0;
                  if (occupancy > 0) occupancy--;
               end
            end
            // new key goes to the lowest free slot
            for (int i = 0; i < ENTRIES; i++) begin
               if (!placed && !slot_live[i]) begin
                  placed        = 1'b1;
                  slot_live[i]  = 1'b1;
                  slot[i].key   = key;
                  slot[i].value = val;
                  slot[i].count = 1;
                  restamp(i);
                  occupancy++;
               end
            end
         end
         owed_rsp.push_back(want);
      endfunction

      // Compare one accepted response with the oldest owed one
      function void match_response(rsp_data_type got);
         rsp_data_type want;
         results_seen++;
         if (owed_rsp.size() == 0) begin
            $error("response item with no request outstanding");
            failures++;
            return;
         end
         want = owed_rsp.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            failures++;
         end
         if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
            failures++;
         end
         if (got.evicted !== want.evicted) begin
            $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
            failures++;
         end
         if (got.evicted_key !== want.evicted_key) begin
            $error("evicted_key: expected %h, actual %h", want.evicted_key,
                   got.evicted_key);
            failures++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, channels, block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   lfu_req_if req_ch ();
   lfu_rsp_if rsp_ch ();
   lfu_csr_if csr_ch ();

   lfu_cache_table DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   lfu_shadow_table   shadow = new();
   int                sent_items = 0;
   int                hold_left  = 0;
   bit                held       = 1'b0;
   logic [WORD_W-1:0] key_pool [POOL_MAX];

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   task automatic offer_request(input logic op, input logic [WORD_W-1:0] key,
                                input logic [WORD_W-1:0] val);
      int gap;
      gap = 0;
      // no idling on items 500..649
      if (!(sent_items >= 500 && sent_items < 650) && $urandom_range(99) < 17)
         gap = $urandom_range(24, 1);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= op;
      req_ch.lookup_key  <= key;
      req_ch.write_value <= val;
      do @(posedge clock); while (!req_ch.ready);
      shadow.take_request(op, key, val);
      sent_items++;
   endtask

   // Stop offering and wait until every owed response has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (shadow.owed_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= cap;
      do @(posedge clock); while (!csr_ch.ready);
      shadow.set_capacity(cap);
      csr_ch.valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Response side: check, random stalls, one long hold-off
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            shadow.match_response({rsp_ch.hit, rsp_ch.read_value,
                                   rsp_ch.evicted, rsp_ch.evicted_key});
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!held && shadow.results_seen >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (shadow.results_seen >= 600 && shadow.results_seen < 750) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 17);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [CAP_W-1:0]  phase_cap [12];
      logic [CAP_W-1:0]  cap;
      logic [WORD_W-1:0] key;
      int                cap_eff;
      int                n_pool;
      int                n_items;

      req_ch.valid       <= 1'b0;
      req_ch.op          <= OP_GET;
      req_ch.lookup_key  <= '0;
      req_ch.write_value <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.data        <= '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset capacity, extreme keys and values, hit/miss/overwrite
      offer_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
      offer_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      offer_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      offer_request(OP_GET, 32'h1234_5678, 32'h0000_0000);
      offer_request(OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
      offer_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
      offer_request(OP_PUT, 32'h0000_0011, 32'h5A5A_5A5A);
      offer_request(OP_PUT, 32'h0000_0022, 32'h0F0F_0F0F);

      // Capacity below occupancy; equal counts fall back to oldest stamp
      write_capacity(5'd2);
      offer_request(OP_PUT, 32'h0000_0033, 32'h1111_1111);
      offer_request(OP_PUT, 32'h0000_0044, 32'h2222_2222);
      write_capacity(5'd1);
      offer_request(OP_GET, 32'h0000_0044, 32'h0000_0000);
      offer_request(OP_PUT, 32'h0000_0055, 32'h3333_3333);

      // Capacity zero: new keys dropped, present keys still update
      write_capacity(5'd0);
      offer_request(OP_PUT, 32'h0000_0066, 32'h4444_4444);
      offer_request(OP_GET, 32'h0000_0066, 32'h0000_0000);
      offer_request(OP_PUT, 32'h0000_0055, 32'hF0F0_F0F0);

      // Capacity above the table size clamps to it
      write_capacity(5'd31);
      offer_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      offer_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      offer_request(OP_GET, 32'h8000_0000, 32'h0000_0000);

      // Random phases over a pool of keys so hits and evictions are common
      phase_cap = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd2, 5'd16, 5'd9, 5'd17,
                    5'(($urandom_range(31, 1))), 5'(($urandom_range(31, 1))),
                    5'd3};
      foreach (key_pool[i]) key_pool[i] = $urandom;

      foreach (phase_cap[p]) begin
         cap = phase_cap[p];
         write_capacity(cap);
         cap_eff = (cap > ENTRIES) ? ENTRIES : int'(cap);
         n_pool  = cap_eff + cap_eff / 2 + 2;
         if (n_pool > POOL_MAX) n_pool = POOL_MAX;
         n_items = (cap == 0) ? ITEMS_CAP_ZERO : ITEMS_PER_RUN;
         // refresh a few pool keys each phase
         repeat (4) key_pool[$urandom_range(POOL_MAX - 1)] = $urandom;
         repeat (n_items) begin
            if ($urandom_range(9) == 0) key = $urandom;
            else key = key_pool[$urandom_range(n_pool - 1)];
            offer_request(1'($urandom_range(1)), key, $urandom);
         end
      end

      // Drain and report
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.owed_rsp.size() != 0) begin
         $error("%0d response items never arrived", shadow.owed_rsp.size());
         shadow.failures++;
      end
      if (shadow.failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/lfu_pkg.sv
rtl/core/lfu_if.sv
rtl/core/lfu_scan_unit.sv
rtl/core/lfu_cache_table.sv
tb/sv/lfu_cache_table_test.sv
